@@ design/msp_dfr_pkg.sv @@
// Shared constants, types and the CRC-8 step for the MSP v1/v2 deframer.
`timescale 1ns / 1ps

package msp_dfr_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int STORE_DEPTH = MAX_PAYLOAD + 9;
    localparam int BUF_AW      = $clog2(STORE_DEPTH);
    localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
    localparam int SIZE_W      = $clog2(MAX_PAYLOAD + 1);

    typedef logic [BUF_AW-1:0] t_ptr;
    typedef logic [FILL_W-1:0] t_fill;
    typedef logic [SIZE_W-1:0] t_size;

    localparam logic [7:0] CHR_DOLLAR = 8'h24;
    localparam logic [7:0] CHR_M      = 8'h4D;
    localparam logic [7:0] CHR_X      = 8'h58;
    localparam logic [7:0] CRC_POLY   = 8'hD5;

    localparam t_fill HDR_V1 = FILL_W'(5);
    localparam t_fill HDR_V2 = FILL_W'(8);

    // feed outcome codes
    localparam logic [1:0] OC_NONE   = 2'd0;
    localparam logic [1:0] OC_GOOD   = 2'd1;
    localparam logic [1:0] OC_REWIND = 2'd2;

    typedef struct packed {
        logic feed_in;    // feed the accepted input word
        logic feed_mem;   // feed the buffered byte at the read pointer
        logic hunt;       // abandon any partial frame
        logic emit_sel;   // buffer read address follows the emit index
        logic emit_load;  // load one result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] outcome;
        logic       more_after;
        logic       pending;
        logic       out_free;
        logic       emit_last;
    } t_dp_sts;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

@@ design/msp_v1_v2_frame_deframer.sv @@
// Top level of the MSP v1/v2 frame deframer.
`timescale 1ns / 1ps
// Input stream: one raw byte per word on s_axis_tdata, s_axis_tlast marks the
// final byte of a datagram. Output stream: one word per payload byte of each
// good frame, or one marker word (tuser low) for a frame with empty payload;
// m_axis_tlast marks the final word of a frame.
// Throughput: while parsing, one input word per cycle. After a bad check, or a
// byte other than 'M'/'X' after '$', the buffered bytes following the '$' are
// replayed from the internal byte buffer (registered buffer read, then parse);
// input is held off meanwhile. A good frame's payload is read back from the
// buffer, one registered read per result word, also with input held off. The
// first result word is read in C_EMIT_RD, then loaded in C_EMIT once the output
// register is free. The output register lets the input side keep running while
// a word waits; when the receiver stalls during emission, emission pauses.
// Reset: synchronous, active low; the parser returns to hunting for '$', the
// buffer is empty and no output word is valid. No clearing pass is needed.

module msp_v1_v2_frame_deframer import msp_dfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // [0] version, [16:1] command,
                                       // [22:17] payload_length, [27:23] byte_index,
                                       // [35:28] payload_byte, [39:36] zero
    output logic        m_axis_tuser,  // [0] has_byte
    output logic        m_axis_tlast
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    msp_dfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    msp_dfr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data      (s_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_has   (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

@@ design/msp_dfr_dp.sv @@
// Datapath: replay buffer, frame parser registers and output register.
`timescale 1ns / 1ps

module msp_dfr_dp import msp_dfr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_data,
    input  t_dp_cmd     i_cmd,
    output t_dp_sts     o_sts,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [39:0] o_out_data,
    output logic        o_out_has,
    output logic        o_out_last
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_DOLLAR  = 3'd1;
    localparam logic [2:0] PH_DIR     = 3'd2;
    localparam logic [2:0] PH_HEADER  = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_CHECK   = 3'd5;

    localparam t_fill IDX_V1_SIZE   = FILL_W'(3);
    localparam t_fill IDX_V2_CMD_LO = FILL_W'(4);
    localparam t_fill IDX_V2_CMD_HI = FILL_W'(5);
    localparam t_fill IDX_V2_SIZE   = FILL_W'(6);

    logic [7:0]  r_mem [2**BUF_AW];
    logic [7:0]  r_rd_data;

    logic [2:0]  r_phase, n_phase;
    t_fill       r_fill, n_fill;
    logic        r_version, n_version;
    logic [7:0]  r_tmp, n_tmp;
    logic [15:0] r_cmd, n_cmd;
    t_size       r_size, n_size;
    logic [7:0]  r_check, n_check;
    t_ptr        r_sp, n_sp;
    t_ptr        r_rp, n_rp;
    t_ptr        r_wp, n_wp;
    t_size       r_k, n_k;

    logic        r_out_valid;
    logic [39:0] r_out_data;
    logic        r_out_has;
    logic        r_out_last;

    logic        feed_any;
    logic [7:0]  b;
    t_ptr        pos;
    t_ptr        rd_addr;
    t_fill       hdr;
    t_fill       fill_nx;
    logic [7:0]  chk_nx;
    logic [15:0] size_full;
    logic        drop;
    logic [1:0]  outcome;
    logic        emit_last;
    logic        has;

    assign feed_any = i_cmd.feed_in | i_cmd.feed_mem;
    assign b        = i_cmd.feed_in ? i_data : r_rd_data;
    assign pos      = i_cmd.feed_in ? r_wp : r_rp;
    assign hdr      = r_version ? HDR_V2 : HDR_V1;
    assign fill_nx  = r_fill + 1'b1;
    assign chk_nx   = r_version ? crc8_step(r_check, b) : (r_check ^ b);
    assign size_full = r_version ? {b, r_tmp} : {8'h00, r_tmp};
    assign rd_addr  = i_cmd.emit_sel ? (r_sp + BUF_AW'(hdr) + BUF_AW'(r_k)) : r_rp;

    assign has       = (r_size != '0);
    assign emit_last = !has || (r_k + 1'b1 == r_size);

    always_comb begin
        n_phase   = r_phase;
        n_fill    = r_fill;
        n_version = r_version;
        n_tmp     = r_tmp;
        n_cmd     = r_cmd;
        n_size    = r_size;
        n_check   = r_check;
        n_sp      = r_sp;
        n_rp      = r_rp;
        n_wp      = r_wp;
        n_k       = r_k;
        outcome   = OC_NONE;
        drop      = 1'b0;

        if (i_cmd.feed_in) begin
            n_wp = r_wp + 1'b1;
            n_rp = r_wp + 1'b1;
        end else if (i_cmd.feed_mem) begin
            n_rp = r_rp + 1'b1;
        end

        if (feed_any) begin
            case (r_phase)
                PH_HUNT: begin
                    if (b == CHR_DOLLAR) begin
                        n_sp    = pos;
                        n_fill  = FILL_W'(1);
                        n_phase = PH_DOLLAR;
                    end
                end
                PH_DOLLAR: begin
                    if (b == CHR_M || b == CHR_X) begin
                        n_version = (b == CHR_X);
                        n_fill    = fill_nx;
                        n_phase   = PH_DIR;
                    end else begin
                        outcome = OC_REWIND;
                    end
                end
                PH_DIR: begin
                    n_fill  = fill_nx;
                    n_check = 8'h00;
                    n_phase = PH_HEADER;
                end
                PH_HEADER: begin
                    n_fill  = fill_nx;
                    n_check = chk_nx;
                    if (!r_version) begin
                        if (r_fill == IDX_V1_SIZE) begin
                            n_tmp = b;
                        end else begin
                            n_cmd = {8'h00, b};
                        end
                    end else begin
                        if (r_fill == IDX_V2_CMD_LO || r_fill == IDX_V2_SIZE) begin
                            n_tmp = b;
                        end
                        if (r_fill == IDX_V2_CMD_HI) begin
                            n_cmd = {b, r_tmp};
                        end
                    end
                    if (fill_nx == hdr) begin
                        if (size_full > 16'(MAX_PAYLOAD)) begin
                            drop = 1'b1;
                        end else begin
                            n_size  = SIZE_W'(size_full);
                            n_phase = (size_full != 16'h0000) ? PH_PAYLOAD : PH_CHECK;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_fill  = fill_nx;
                    n_check = chk_nx;
                    if (fill_nx == hdr + FILL_W'(r_size)) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    outcome = (b == r_check) ? OC_GOOD : OC_REWIND;
                end
                default: begin
                    drop = 1'b1;
                end
            endcase

            if (drop || outcome != OC_NONE) begin
                n_phase = PH_HUNT;
                n_fill  = '0;
                n_check = 8'h00;
            end
            if (outcome == OC_REWIND) begin
                n_rp = r_sp + 1'b1;
            end
            if (outcome == OC_GOOD) begin
                n_k = '0;
            end
        end

        if (i_cmd.hunt) begin
            n_phase = PH_HUNT;
            n_fill  = '0;
            n_check = 8'h00;
        end
        if (i_cmd.emit_load) begin
            n_k = r_k + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.feed_in) begin
            r_mem[r_wp] <= i_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_fill      <= '0;
            r_version   <= 1'b0;
            r_check     <= 8'h00;
            r_sp        <= '0;
            r_rp        <= '0;
            r_wp        <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_fill    <= n_fill;
            r_version <= n_version;
            r_check   <= n_check;
            r_sp      <= n_sp;
            r_rp      <= n_rp;
            r_wp      <= n_wp;
            r_k       <= n_k;
            if (i_cmd.emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tmp  <= n_tmp;
        r_cmd  <= n_cmd;
        r_size <= n_size;
        if (i_cmd.emit_load) begin
            r_out_data <= {4'h0, (has ? r_rd_data : 8'h00), 5'(r_k), 6'(r_size),
                           r_cmd, r_version};
            r_out_has  <= has;
            r_out_last <= emit_last;
        end
    end

    assign o_sts.outcome    = outcome;
    assign o_sts.more_after = (n_rp != n_wp);
    assign o_sts.pending    = (r_rp != r_wp);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_sts.emit_last  = emit_last;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_has   = r_out_has;
    assign o_out_last  = r_out_last;

endmodule

@@ design/msp_dfr_ctrl.sv @@
// Controller: sequences input feed, buffer replay and payload emission.
`timescale 1ns / 1ps

module msp_dfr_ctrl import msp_dfr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_last,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] C_IDLE    = 3'd0;
    localparam logic [2:0] C_READ    = 3'd1;
    localparam logic [2:0] C_FEED    = 3'd2;
    localparam logic [2:0] C_EMIT_RD = 3'd3;
    localparam logic [2:0] C_EMIT    = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_eod, n_eod;
    logic       accept;

    assign o_in_ready = (r_state == C_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        n_eod   = r_eod;
        o_cmd   = '0;
        case (r_state)
            C_IDLE: begin
                if (accept) begin
                    o_cmd.feed_in = 1'b1;
                    n_eod         = i_in_last;
                    if (i_sts.outcome == OC_GOOD) begin
                        n_state = C_EMIT_RD;
                    end else if (i_sts.more_after) begin
                        n_state = C_READ;
                    end else if (i_in_last) begin
                        o_cmd.hunt = 1'b1;
                    end
                end
            end
            C_READ: begin
                n_state = C_FEED;
            end
            C_FEED: begin
                o_cmd.feed_mem = 1'b1;
                if (i_sts.outcome == OC_GOOD) begin
                    n_state = C_EMIT_RD;
                end else if (i_sts.more_after) begin
                    n_state = C_READ;
                end else begin
                    o_cmd.hunt = r_eod;
                    n_state    = C_IDLE;
                end
            end
            C_EMIT_RD: begin
                o_cmd.emit_sel = 1'b1;
                n_state        = C_EMIT;
            end
            C_EMIT: begin
                o_cmd.emit_sel = 1'b1;
                if (i_sts.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    if (!i_sts.emit_last) begin
                        n_state = C_EMIT_RD;
                    end else if (i_sts.pending) begin
                        n_state = C_READ;
                    end else begin
                        o_cmd.hunt = r_eod;
                        n_state    = C_IDLE;
                    end
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_eod   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eod   <= n_eod;
        end
    end

endmodule
